[design/envelope_feedforward_compressor_assert.svh]
// Assertion macros for the envelope feed-forward compressor.
// Used by the top level only; needs a clock and an active-low reset in scope.
`ifndef ENVELOPE_FEEDFORWARD_COMPRESSOR_ASSERT_SVH
`define ENVELOPE_FEEDFORWARD_COMPRESSOR_ASSERT_SVH

// Same-cycle implication.
`define EFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/efc_pkg.sv]
// Shared types, constants and encodings for the envelope compressor.
// No dependencies; imported by every module of the block.
package efc_pkg;

    localparam int SampleBits     = 24;
    localparam int EnvBits        = 32;
    localparam int EnvShift       = EnvBits - SampleBits;
    localparam int ThrBits        = 24;
    localparam int CoeffBits      = 16;
    localparam int MakeupFrac     = 14;
    localparam int GainFrac       = 24;
    localparam int GainBits       = GainFrac + 1;
    localparam int DivSteps       = GainBits;
    localparam int CntBits        = $clog2(DivSteps);
    localparam int MulABits       = EnvBits;
    localparam int MulBBits       = GainBits;
    localparam int ProdBits       = MulABits + MulBBits;
    localparam int OmagBits       = SampleBits + 2;
    localparam int DataBits       = 32;
    localparam int CfgAddrBits    = 5;
    localparam int DefNumChannels = 2;

    localparam logic [GainBits-1:0]   GainOne  = GainBits'(1) << GainFrac;
    localparam logic [OmagBits-1:0]   SatNeg   = OmagBits'(1) << (SampleBits - 1);
    localparam logic [OmagBits-1:0]   SatPos   = SatNeg - OmagBits'(1);

    localparam logic [ThrBits-1:0]    ThresholdRst = 24'd8388608;
    localparam logic [CoeffBits-1:0]  RatioRst     = 16'd65535;
    localparam logic [CoeffBits-1:0]  AttackRst    = 16'd65535;
    localparam logic [CoeffBits-1:0]  ReleaseRst   = 16'd65535;
    localparam logic [CoeffBits-1:0]  MakeupRst    = 16'd16384;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_RATIO     = 3'd1,
        REG_ATTACK    = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_MAKEUP    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                         channel_in;
        logic signed [SampleBits-1:0] sample_in;
    } t_in_beat;

    typedef struct packed {
        logic                         channel_out;
        logic signed [SampleBits-1:0] sample_out;
    } t_out_beat;

    typedef struct packed {
        logic [ThrBits-1:0]   threshold;
        logic [CoeffBits-1:0] ratio_reciprocal;
        logic [CoeffBits-1:0] attack_coeff;
        logic [CoeffBits-1:0] release_coeff;
        logic [CoeffBits-1:0] makeup_gain;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_MUL,
        ST_SM_ADD,
        ST_GN_MUL,
        ST_GN_ADD,
        ST_DIV,
        ST_OUT_MUL1,
        ST_OUT_MUL2,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic sm_mul;
        logic env_wr;
        logic gn_mul;
        logic unity;
        logic gn_load;
        logic div_step;
        logic out_mul1;
        logic out_mul2;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic env_gt_thr;
        logic out_free;
    } t_dp_stat;

endpackage

[design/efc_regs.sv]
// APB-style configuration registers of the envelope compressor.
// Depends on efc_pkg.
module efc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efc_pkg::CfgAddrBits-1:0] paddr,
    input  logic [efc_pkg::DataBits-1:0]    pwdata,
    output logic [efc_pkg::DataBits-1:0]    prdata,
    output logic                            pready,
    output efc_pkg::t_cfg                   o_cfg
);
    import efc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CfgAddrBits-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_THRESHOLD: n_cfg.threshold        = pwdata[ThrBits-1:0];
                REG_RATIO:     n_cfg.ratio_reciprocal = pwdata[CoeffBits-1:0];
                REG_ATTACK:    n_cfg.attack_coeff     = pwdata[CoeffBits-1:0];
                REG_RELEASE:   n_cfg.release_coeff    = pwdata[CoeffBits-1:0];
                REG_MAKEUP:    n_cfg.makeup_gain      = pwdata[CoeffBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLD: prdata = DataBits'(r_cfg.threshold);
            REG_RATIO:     prdata = DataBits'(r_cfg.ratio_reciprocal);
            REG_ATTACK:    prdata = DataBits'(r_cfg.attack_coeff);
            REG_RELEASE:   prdata = DataBits'(r_cfg.release_coeff);
            REG_MAKEUP:    prdata = DataBits'(r_cfg.makeup_gain);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold        <= ThresholdRst;
            r_cfg.ratio_reciprocal <= RatioRst;
            r_cfg.attack_coeff     <= AttackRst;
            r_cfg.release_coeff    <= ReleaseRst;
            r_cfg.makeup_gain      <= MakeupRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[design/efc_ctrl.sv]
// Sequencing state machine of the envelope compressor: issues datapath commands.
// Depends on efc_pkg.
module efc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  efc_pkg::t_dp_stat i_stat,
    output efc_pkg::t_dp_cmd  o_cmd
);
    import efc_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CntBits-1:0]  r_cnt;
    logic [CntBits-1:0]  n_cnt;

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_SM_MUL;
                end
            end
            ST_SM_MUL: begin
                o_cmd.sm_mul = 1'b1;
                n_state      = ST_SM_ADD;
            end
            ST_SM_ADD: begin
                o_cmd.env_wr = 1'b1;
                n_state      = ST_GN_MUL;
            end
            ST_GN_MUL: begin
                // at or below threshold the gain is unity and the divide is skipped
                if (i_stat.env_gt_thr) begin
                    o_cmd.gn_mul = 1'b1;
                    n_state      = ST_GN_ADD;
                end else begin
                    o_cmd.unity = 1'b1;
                    n_state     = ST_OUT_MUL1;
                end
            end
            ST_GN_ADD: begin
                o_cmd.gn_load = 1'b1;
                n_cnt         = '0;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CntBits'(DivSteps - 1)) begin
                    n_state = ST_OUT_MUL1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT_MUL1: begin
                o_cmd.out_mul1 = 1'b1;
                n_state        = ST_OUT_MUL2;
            end
            ST_OUT_MUL2: begin
                o_cmd.out_mul2 = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/efc_dp.sv]
// Datapath of the envelope compressor: envelopes, shared multiplier, serial
// gain divider and output register. Depends on efc_pkg.
module efc_dp #(
    parameter int NUM_CHANNELS = efc_pkg::DefNumChannels
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  efc_pkg::t_cfg      i_cfg,
    input  efc_pkg::t_in_beat  i_in_beat,
    output efc_pkg::t_out_beat o_out_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  efc_pkg::t_dp_cmd   i_cmd,
    output efc_pkg::t_dp_stat  o_stat
);
    import efc_pkg::*;

    localparam int IdxBits = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [EnvBits-1:0]    r_env_mem [NUM_CHANNELS];
    logic [IdxBits-1:0]    r_idx;
    logic                  r_chan;
    logic                  r_neg;
    logic [SampleBits-1:0] r_mag;
    logic [EnvBits-1:0]    r_env;
    logic [ProdBits-1:0]   r_prod;
    logic [EnvBits:0]      r_rem;
    logic [GainBits-1:0]   r_gain;
    logic                  r_out_valid;
    t_out_beat             r_out_beat;

    logic [IdxBits-1:0]    n_idx;
    logic [SampleBits-1:0] n_mag;
    logic [EnvBits-1:0]    n_env;
    logic [EnvBits-1:0]    w_mag31;
    logic [EnvBits-1:0]    w_thr;
    logic [EnvBits-1:0]    w_diff;
    logic [EnvBits-1:0]    w_step;
    logic                  w_grow;
    logic [CoeffBits-1:0]  w_coeff;
    logic [MulABits-1:0]   w_mul_a;
    logic [MulBBits-1:0]   w_mul_b;
    logic                  w_ge;
    logic [EnvBits:0]      w_sub;
    logic [OmagBits-1:0]   w_omag;
    logic [OmagBits-1:0]   w_sat;
    logic [SampleBits-1:0] w_sat_lo;

    // channel numbers past the last envelope share the last one
    always_comb begin
        if (32'(i_in_beat.channel_in) < NUM_CHANNELS) begin
            n_idx = IdxBits'(i_in_beat.channel_in);
        end else begin
            n_idx = IdxBits'(NUM_CHANNELS - 1);
        end
    end

    assign n_mag   = i_in_beat.sample_in[SampleBits-1] ?
                     (~i_in_beat.sample_in + 1'b1) : i_in_beat.sample_in;
    assign w_mag31 = {r_mag, {EnvShift{1'b0}}};
    assign w_thr   = {i_cfg.threshold, {(EnvBits - ThrBits){1'b0}}};
    assign w_grow  = (w_mag31 >= r_env);
    assign w_diff  = w_grow ? (w_mag31 - r_env) : (r_env - w_mag31);
    assign w_coeff = (w_mag31 > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign w_step  = r_prod[CoeffBits +: EnvBits];
    assign n_env   = w_grow ? (r_env + w_step) : (r_env - w_step);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (i_cmd.sm_mul) begin
            w_mul_a = w_diff;
            w_mul_b = MulBBits'(w_coeff);
        end else if (i_cmd.gn_mul) begin
            w_mul_a = r_env - w_thr;
            w_mul_b = MulBBits'(i_cfg.ratio_reciprocal);
        end else if (i_cmd.out_mul1) begin
            w_mul_a = MulABits'(r_mag);
            w_mul_b = r_gain;
        end else if (i_cmd.out_mul2) begin
            w_mul_a = MulABits'(r_prod[GainFrac +: SampleBits]);
            w_mul_b = MulBBits'(i_cfg.makeup_gain);
        end
    end

    // restoring divide, one quotient bit a cycle; remainder stays below twice the envelope
    assign w_ge  = (r_rem >= {1'b0, r_env});
    assign w_sub = w_ge ? (r_rem - {1'b0, r_env}) : r_rem;

    assign w_omag   = r_prod[MakeupFrac +: OmagBits];
    assign w_sat    = r_neg ? ((w_omag > SatNeg) ? SatNeg : w_omag)
                            : ((w_omag > SatPos) ? SatPos : w_omag);
    assign w_sat_lo = w_sat[SampleBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_env_mem[k] <= '0;
            end
        end else if (i_cmd.env_wr) begin
            r_env_mem[r_idx] <= n_env;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx  <= n_idx;
            r_chan <= i_in_beat.channel_in;
            r_neg  <= i_in_beat.sample_in[SampleBits-1];
            r_mag  <= n_mag;
            r_env  <= r_env_mem[n_idx];
        end else if (i_cmd.env_wr) begin
            r_env  <= n_env;
        end
        if (i_cmd.sm_mul || i_cmd.gn_mul || i_cmd.out_mul1 || i_cmd.out_mul2) begin
            r_prod <= ProdBits'(w_mul_a) * ProdBits'(w_mul_b);
        end
        if (i_cmd.gn_load) begin
            r_rem  <= (EnvBits + 1)'(w_thr + w_step);
            r_gain <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= {w_sub[EnvBits-1:0], 1'b0};
            r_gain <= {r_gain[GainBits-2:0], w_ge};
        end else if (i_cmd.unity) begin
            r_gain <= GainOne;
        end
        if (i_cmd.out_load) begin
            r_out_beat.channel_out <= r_chan;
            r_out_beat.sample_out  <= r_neg ? (~w_sat_lo + 1'b1) : w_sat_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.env_gt_thr = (r_env > w_thr);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out_beat;

endmodule

[design/envelope_feedforward_compressor.sv]
// Each beat updates its channel's envelope; at or below threshold the gain is unity,
// above it the gain comes from the 25-step serial gain divider. The input is closed
// until the result is loaded into the output register; a finished result waits in the
// output register while the next beat is taken and worked on.
// Reset: synchronous, active low; clears envelopes to zero, registers to defaults.
`include "envelope_feedforward_compressor_assert.svh"

module envelope_feedforward_compressor #(
    parameter int NUM_CHANNELS = efc_pkg::DefNumChannels
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  efc_pkg::t_in_beat               i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output efc_pkg::t_out_beat              o_out_beat,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [efc_pkg::CfgAddrBits-1:0] paddr,
    input  logic [efc_pkg::DataBits-1:0]    pwdata,
    output logic [efc_pkg::DataBits-1:0]    prdata,
    output logic                            pready
);
    import efc_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    efc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    efc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    efc_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_beat   (i_in_beat),
        .o_out_beat  (o_out_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    // one item in flight: a taken beat closes the input until its result is stored
    `EFC_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input open after beat")
    // a new result only appears at the end of an item's sequence
    `EFC_ASSERT_IMP(a_result_from_item, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without item")
    // the controller never issues two datapath commands at once
    `EFC_ASSERT_IMP(a_single_cmd, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "overlapping datapath commands")

endmodule
